### src/lvepc_pkg.sv
// ---------------------------------------------------------------------------
// lvepc_pkg: shared types and constants
// Payload structs, register indexes and frame size limits for the
// bottom-up column edge scanner.
// ---------------------------------------------------------------------------
package lvepc_pkg;

  // Frame size limits
  localparam int unsigned MAX_WIDTH  = 256;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned MIN_WIDTH  = 2;
  localparam int unsigned MIN_HEIGHT = 3;

  // Field widths
  localparam int unsigned CHAN_W = 8;
  localparam int unsigned COORD_W = 8;
  localparam int unsigned SIZE_W = 9;
  localparam int unsigned THR_W = 10;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values
  localparam logic [SIZE_W-1:0] WIDTH_RST  = 9'd160;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 9'd120;
  localparam logic [THR_W-1:0]  THR_RST    = 10'd100;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_FRAME_WIDTH    = 2'd0,
    REG_FRAME_HEIGHT   = 2'd1,
    REG_EDGE_THRESHOLD = 2'd2
  } cfg_reg_t;

  // Input pixel
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_start;
  } in_t;

  // Per-column result
  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic               edge_found;
    logic [COORD_W-1:0] edge_row;
    logic               last_column;
  } out_t;

endpackage

### src/lowest_vertical_edge_per_column.sv
// ---------------------------------------------------------------------------
// lowest_vertical_edge_per_column: bottom-most vertical edge per column
// Scans an RGB raster stream and reports, per column, the lowest row where
// the summed channel difference to the row below exceeds a threshold.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : one pixel per transfer, raster order, top row first. frame_start
//           restarts the row and column counters; after the last pixel of a
//           frame the counters wrap on their own.
//   out_* : one result per column, emitted with the last-row pixel of that
//           column; last_column marks the final column of the frame.
//   cfg_* : frame_width, frame_height, edge_threshold; write only when idle.
// Throughput: one pixel per clock unless a held result stalls a last-row
//   pixel, set by the line buffer and edge row store (one read and one
//   write per cycle each, bypassed on a clash).
// Order: pixel register at the transfer, then the result register.
// Reset clears the counters, pipeline valid flags, per-column found flags
//   and the configuration registers to 160 x 120, threshold 100.
// When the receiver stalls, the result register holds; a last-row pixel in
//   the pixel stage waits behind it and in_ready falls; nothing is dropped.
// ---------------------------------------------------------------------------
module lowest_vertical_edge_per_column
  import lvepc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned PIX_W = 3 * CHAN_W;
  localparam int unsigned IDX_W = $clog2(MAX_WIDTH);

  // Configuration registers
  logic [SIZE_W-1:0] frame_width_r, frame_height_r;
  logic [THR_W-1:0]  edge_threshold_r;

  // Counters
  logic [COORD_W-1:0] col_r, row_r, col_nxt, row_nxt;

  // Stage 1 (pixel register)
  logic               s1_valid_r;
  logic [PIX_W-1:0]   s1_pix_r;
  logic [COORD_W-1:0] s1_x_r, s1_y_r;
  logic               s1_row0_r, s1_cmp_r, s1_last_row_r, s1_last_col_r;

  // Memories and bypass
  logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
  logic [COORD_W-1:0] erow_mem [MAX_WIDTH];
  logic [PIX_W-1:0]   line_rd_r;
  logic [COORD_W-1:0] erow_rd_r;
  logic               fwd_pix_r, fwd_row_r;
  logic [PIX_W-1:0]   fwd_pix_d_r;
  logic [COORD_W-1:0] fwd_row_d_r;
  logic [MAX_WIDTH-1:0] found_r;

  // Output register
  logic out_valid_r;
  out_t out_data_r;

  // Stage 0 signals
  logic               accept, adv1;
  logic [SIZE_W-1:0]  w_clamp, h_clamp;
  logic [COORD_W-1:0] x0, y0;
  logic [SIZE_W-1:0]  x0_inc, y0_inc, h_last;
  logic               last_col0;

  // Stage 1 signals
  logic [PIX_W-1:0]   prev_pix;
  logic [COORD_W-1:0] prev_row;
  logic [CHAN_W-1:0]  d_r, d_g, d_b;
  logic [THR_W-1:0]   sum;
  logic               hit, found_new;
  logic [COORD_W-1:0] hit_row;
  logic [IDX_W-1:0]   s1_idx, x0_idx;

  function automatic logic [CHAN_W-1:0] absdiff(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= WIDTH_RST;
      frame_height_r   <= HEIGHT_RST;
      edge_threshold_r <= THR_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:    frame_width_r    <= cfg_wdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   frame_height_r   <= cfg_wdata[SIZE_W-1:0];
        REG_EDGE_THRESHOLD: edge_threshold_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturated frame sizes
  always_comb begin
    if (frame_width_r < SIZE_W'(MIN_WIDTH))       w_clamp = SIZE_W'(MIN_WIDTH);
    else if (frame_width_r > SIZE_W'(MAX_WIDTH))  w_clamp = SIZE_W'(MAX_WIDTH);
    else                                          w_clamp = frame_width_r;
    if (frame_height_r < SIZE_W'(MIN_HEIGHT))     h_clamp = SIZE_W'(MIN_HEIGHT);
    else if (frame_height_r > SIZE_W'(MAX_HEIGHT)) h_clamp = SIZE_W'(MAX_HEIGHT);
    else                                          h_clamp = frame_height_r;
  end

  // Handshake: stage 1 moves on unless its result would hit a full output
  assign adv1     = s1_valid_r && (!s1_last_row_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv1;
  assign accept   = in_valid && in_ready;

  // Stage 0: position of the incoming pixel and counter update
  always_comb begin
    x0        = in_data.frame_start ? '0 : col_r;
    y0        = in_data.frame_start ? '0 : row_r;
    x0_inc    = {1'b0, x0} + 1'b1;
    y0_inc    = {1'b0, y0} + 1'b1;
    h_last    = h_clamp - 1'b1;
    last_col0 = x0_inc >= w_clamp;
    x0_idx    = x0[IDX_W-1:0];
    if (last_col0) begin
      col_nxt = '0;
      row_nxt = (y0_inc >= h_clamp) ? '0 : y0_inc[COORD_W-1:0];
    end else begin
      col_nxt = x0_inc[COORD_W-1:0];
      row_nxt = y0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Stage 1 register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r      <= {in_data.red, in_data.green, in_data.blue};
      s1_x_r        <= x0;
      s1_y_r        <= y0;
      s1_row0_r     <= (y0 == '0);
      s1_cmp_r      <= (y0 >= COORD_W'(2)) && ({1'b0, y0} <= h_last);
      s1_last_row_r <= ({1'b0, y0} == h_last);
      s1_last_col_r <= last_col0;
    end
  end

  // Stage 1: edge test against the stored pixel above
  always_comb begin
    s1_idx    = s1_x_r[IDX_W-1:0];
    prev_pix  = fwd_pix_r ? fwd_pix_d_r : line_rd_r;
    prev_row  = fwd_row_r ? fwd_row_d_r : erow_rd_r;
    d_r       = absdiff(prev_pix[3*CHAN_W-1:2*CHAN_W], s1_pix_r[3*CHAN_W-1:2*CHAN_W]);
    d_g       = absdiff(prev_pix[2*CHAN_W-1:CHAN_W],   s1_pix_r[2*CHAN_W-1:CHAN_W]);
    d_b       = absdiff(prev_pix[CHAN_W-1:0],          s1_pix_r[CHAN_W-1:0]);
    sum       = THR_W'(d_r) + THR_W'(d_g) + THR_W'(d_b);
    hit       = s1_cmp_r && (sum > edge_threshold_r);
    hit_row   = s1_y_r - 1'b1;
    if (s1_row0_r)  found_new = 1'b0;
    else if (hit)   found_new = 1'b1;
    else            found_new = found_r[s1_idx];
  end

  // Line buffer: write from stage 1, registered read at stage 0
  always_ff @(posedge clk) begin
    if (adv1) begin
      line_mem[s1_idx] <= s1_pix_r;
    end
    if (accept) begin
      line_rd_r <= line_mem[x0_idx];
    end
  end

  // Edge row store: written on a hit only
  always_ff @(posedge clk) begin
    if (adv1 && hit) begin
      erow_mem[s1_idx] <= hit_row;
    end
    if (accept) begin
      erow_rd_r <= erow_mem[x0_idx];
    end
  end

  // Bypass when stage 1 writes the column that stage 0 reads in the same cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_pix_r <= 1'b0;
      fwd_row_r <= 1'b0;
    end else if (accept) begin
      fwd_pix_r <= adv1 && (s1_idx == x0_idx);
      fwd_row_r <= adv1 && hit && (s1_idx == x0_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_pix_d_r <= s1_pix_r;
      fwd_row_d_r <= hit_row;
    end
  end

  // Per-column found flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
    end else if (adv1 && (s1_row0_r || hit)) begin
      found_r[s1_idx] <= found_new;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv1 && s1_last_row_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && s1_last_row_r) begin
      out_data_r.column      <= s1_x_r;
      out_data_r.edge_found  <= found_new;
      out_data_r.edge_row    <= found_new ? (hit ? hit_row : prev_row) : '0;
      out_data_r.last_column <= s1_last_col_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/sv/lvepc_tb_pkg.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lvepc_tb_pkg: expected-result tracking for the column edge scanner
// Holds a cycle-free behavioral copy of the scanner (line buffer, per-column
// edge rows and flags, raster counters, registers), queues the column
// result each pixel transfer should cause and checks results in order.
// ---------------------------------------------------------------------------
package lvepc_tb_pkg;
  import lvepc_pkg::*;

  class edge_scan_tracker;
    // Register copies
    logic [SIZE_W-1:0]   width_reg;
    logic [SIZE_W-1:0]   height_reg;
    logic [THR_W-1:0]    thr_reg;
    // Scanner state
    logic [3*CHAN_W-1:0] line_buf [MAX_WIDTH];
    bit                  written [MAX_WIDTH];
    logic [COORD_W-1:0]  edge_row [MAX_WIDTH];
    bit                  edge_seen [MAX_WIDTH];
    int unsigned         col;
    int unsigned         row;
    // Column results still owed by the block
    out_t                pending[$];
    int unsigned         errors;

    function new();
      width_reg  = WIDTH_RST;
      height_reg = HEIGHT_RST;
      thr_reg    = THR_RST;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_buf[i]  = '0;
        written[i]   = 1'b0;
        edge_row[i]  = '0;
        edge_seen[i] = 1'b0;
      end
      col    = 0;
      row    = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FRAME_WIDTH:    width_reg  = val[SIZE_W-1:0];
        REG_FRAME_HEIGHT:   height_reg = val[SIZE_W-1:0];
        REG_EDGE_THRESHOLD: thr_reg    = val[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // Sizes as the scanner uses them, saturated into the legal range
    function int unsigned eff_width();
      if (width_reg < MIN_WIDTH) return MIN_WIDTH;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_HEIGHT) return MIN_HEIGHT;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    // True when a pixel without frame_start would compare against a
    // line buffer entry that has never been filled
    function bit reads_unwritten();
      return row >= 2 && row <= eff_height() - 1 && !written[col];
    endfunction

    function int unsigned chan_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
      return (a > b) ? a - b : b - a;
    endfunction

    // Advance the scanner by one accepted pixel
    function void note_pixel(in_t px);
      int unsigned         w;
      int unsigned         h;
      int unsigned         x;
      int unsigned         y;
      int unsigned         sum;
      logic [3*CHAN_W-1:0] above;
      out_t                res;
      w = eff_width();
      h = eff_height();
      if (px.frame_start) begin
        col = 0;
        row = 0;
      end
      x = col;
      y = row;

      // row zero clears the column, rows from two on compare with the row above
      if (y == 0) begin
        edge_seen[x] = 1'b0;
        edge_row[x]  = '0;
      end else if (y >= 2 && y <= h - 1) begin
        above = line_buf[x];
        sum = chan_diff(above[23:16], px.red) + chan_diff(above[15:8], px.green)
            + chan_diff(above[7:0], px.blue);
        if (sum > thr_reg) begin
          edge_row[x]  = COORD_W'(y - 1);
          edge_seen[x] = 1'b1;
        end
      end
      line_buf[x] = {px.red, px.green, px.blue};
      written[x]  = 1'b1;

      // last row of the frame reports the column
      if (y == h - 1) begin
        res.column      = COORD_W'(x);
        res.edge_found  = edge_seen[x];
        res.edge_row    = edge_seen[x] ? edge_row[x] : '0;
        res.last_column = (x + 1 >= w);
        pending.push_back(res);
      end

      // counters wrap at or past the last index
      if (x + 1 >= w) begin
        col = 0;
        row = (y + 1 >= h) ? 0 : y + 1;
      end else begin
        col = x + 1;
      end
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: col %0d found %0d row %0d last %0d",
                   got.column, got.edge_found, got.edge_row, got.last_column);
      end else begin
        want = pending.pop_front();
        if (got.column !== want.column || got.edge_found !== want.edge_found ||
            got.edge_row !== want.edge_row || got.last_column !== want.last_column) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: want col %0d found %0d row %0d last %0d, got col %0d found %0d row %0d last %0d",
                     want.column, want.edge_found, want.edge_row, want.last_column,
                     got.column, got.edge_found, got.edge_row, got.last_column);
        end
      end
    endfunction
  endclass

endpackage

### tb/sv/lowest_vertical_edge_per_column_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// lowest_vertical_edge_per_column_tb: self-checking bench for the scanner
// Streams pixel frames over several frame sizes and thresholds, starting
// with a short hand-picked sequence (full-scale swings, threshold boundary,
// wrap without frame_start, mid-frame restart, width lowered mid-frame),
// then random-content frames with stray restarts and cut-off frames.
// Every column result is checked in order against a behavioral tracker.
// ---------------------------------------------------------------------------
module lowest_vertical_edge_per_column_tb;
  import lvepc_pkg::*;
  import lvepc_tb_pkg::*;

  localparam int unsigned PIXEL_TARGET  = 1850;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned SETTLE_CYCLES = 8;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned           send_idle_pct;
  int unsigned           recv_idle_pct;
  int unsigned           pixels_sent;
  int unsigned           stall_cycles;
  logic [3*CHAN_W-1:0]   column_level [MAX_WIDTH];
  edge_scan_tracker      track;

  lowest_vertical_edge_per_column u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result transfers
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) track.check_result(out_data);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Register write, issued at a falling edge; leaves cfg_we high
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    track.set_reg(idx, val);
    @(negedge clk);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                           input logic [CFG_DATA_W-1:0] thr);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_EDGE_THRESHOLD, thr);
    cfg_we <= 1'b0;
  endtask

  // One pixel transfer; called and returns at a falling edge
  task automatic send_pixel(input in_t px);
    if (!px.frame_start && track.reads_unwritten()) px.frame_start = 1'b1;
    if (pixels_sent < PIXEL_TARGET / 3) begin
      send_idle_pct = 36;
      recv_idle_pct = 57;
    end else if (pixels_sent < 2 * PIXEL_TARGET / 3) begin
      send_idle_pct = 57;
      recv_idle_pct = 36;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track.note_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_rgb(input logic [3*CHAN_W-1:0] rgb, input logic fs);
    in_t px;
    px.red         = rgb[23:16];
    px.green       = rgb[15:8];
    px.blue        = rgb[7:0];
    px.frame_start = fs;
    send_pixel(px);
  endtask

  // Each column drifts slowly with occasional jumps, so edges stay sparse
  task automatic send_random_pixel(input logic fs);
    int unsigned         c;
    logic [3*CHAN_W-1:0] lvl;
    c   = track.col;
    lvl = column_level[c];
    if ($urandom_range(99) < 20) begin
      lvl = $urandom;
    end else begin
      for (int k = 0; k < 3; k++)
        lvl[8*k +: 8] = lvl[8*k +: 8] + 8'($urandom_range(20)) - 8'd10;
    end
    column_level[c] = lvl;
    send_rgb(lvl, fs);
  endtask

  // Whole frames at the current size; noise_pct sets stray restarts
  task automatic send_frames(input int unsigned n_frames, input int unsigned noise_pct);
    int unsigned n_px;
    n_px = track.eff_width() * track.eff_height();
    for (int unsigned f = 0; f < n_frames; f++) begin
      for (int unsigned p = 0; p < n_px; p++) begin
        if (p == 0) send_random_pixel($urandom_range(99) < 80);
        else send_random_pixel($urandom_range(99) < noise_pct);
      end
    end
  endtask

  // Drop valid, wait for all owed results, then let the pipeline empty
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (track.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w_cfg;
    logic [CFG_DATA_W-1:0] h_cfg;
    logic [CFG_DATA_W-1:0] thr_cfg;
    int unsigned           n_px;

    track         = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_FRAME_WIDTH;
    cfg_wdata     = '0;
    send_idle_pct = 36;
    recv_idle_pct = 57;
    pixels_sent   = 0;
    stall_cycles  = 0;
    for (int i = 0; i < MAX_WIDTH; i++) column_level[i] = $urandom;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Smallest frame: full-scale swings give an edge at row 1 in both columns
    configure(10'd2, 10'd3, 10'd100);
    send_rgb(24'h000000, 1'b1);
    send_rgb(24'hFFFFFF, 1'b0);
    send_rgb(24'hFFFFFF, 1'b0);
    send_rgb(24'h000000, 1'b0);
    send_rgb(24'h000000, 1'b0);
    send_rgb(24'hFFFFFF, 1'b0);
    // Next frame rides the wrap; column 0 sums to the threshold, column 1 one over
    send_rgb(24'h0A141E, 1'b0);
    send_rgb(24'h000000, 1'b0);
    send_rgb(24'h0A141E, 1'b0);
    send_rgb(24'h000000, 1'b0);
    send_rgb(24'h3C461E, 1'b0);
    send_rgb(24'h000065, 1'b0);
    wait_idle();

    // Wider frame restarted mid-row, then cut short in row zero
    configure(10'd4, 10'd3, 10'd100);
    send_rgb(24'hFF0000, 1'b1);
    send_rgb(24'h00FF00, 1'b0);
    send_rgb(24'h0000FF, 1'b1);
    send_rgb(24'hFFFFFF, 1'b0);
    send_rgb(24'h808080, 1'b0);
    wait_idle();

    // Width lowered under the column counter: the next pixel wraps the row.
    // Row zero cleared column 1, whose small step must not count.
    configure(10'd2, 10'd3, 10'd100);
    send_rgb(24'h555555, 1'b0);
    send_rgb(24'hFFFFFF, 1'b0);
    send_rgb(24'h000000, 1'b0);
    send_rgb(24'h000000, 1'b0);
    send_rgb(24'h000010, 1'b0);
    wait_idle();

    // Widest frame (width saturates high, height low)
    configure(10'd511, 10'd2, 10'd60);
    send_frames(1, 0);
    wait_idle();

    // Tallest frame (width saturates low)
    configure(10'd1, 10'd256, 10'd60);
    send_frames(1, 0);
    wait_idle();

    // Random settings with short frames, stray restarts and cut-off frames
    while (pixels_sent < PIXEL_TARGET) begin
      w_cfg = CFG_DATA_W'($urandom_range(2, 10));
      h_cfg = CFG_DATA_W'($urandom_range(3, 8));
      if ($urandom_range(9) == 0) w_cfg = CFG_DATA_W'($urandom_range(1));
      if ($urandom_range(9) == 0) h_cfg = CFG_DATA_W'($urandom_range(2));
      if ($urandom_range(4) == 0) w_cfg[CFG_DATA_W-1] = 1'b1;
      if ($urandom_range(4) == 0) h_cfg[CFG_DATA_W-1] = 1'b1;
      case ($urandom_range(3))
        0:       thr_cfg = '0;
        1:       thr_cfg = 10'd765;
        2:       thr_cfg = CFG_DATA_W'($urandom_range(150));
        default: thr_cfg = CFG_DATA_W'($urandom_range(765));
      endcase
      configure(w_cfg, h_cfg, thr_cfg);
      send_frames($urandom_range(1, 3), 2);
      // leave the counters mid-frame for the next setting
      if ($urandom_range(1) == 0) begin
        n_px = track.eff_width() * track.eff_height();
        repeat ($urandom_range(1, n_px - 1)) send_random_pixel($urandom_range(99) < 2);
      end
      wait_idle();
    end

    if (track.errors == 0 && track.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
